@@ hdl/pcs_pkg.sv @@
package pcs_pkg;

  // Width of the nanosecond remainder magnitude and of the slew path dividends
  localparam int NS_W = 30;
  // Width of the proportional and integral divisors
  localparam int DIV_W = 10;
  // Width of the drift accumulator
  localparam int DRIFT_W = 22;

  localparam int NS_PER_SEC = 1000000000;
  localparam int FREQ_SCALE = (1 << 16) / 1000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVS,
    ST_CHECK,
    ST_DIVI,
    ST_DRIFT,
    ST_FREQ
  } state_t;

  typedef enum logic [1:0] {
    CFG_STEP_THR  = 2'd0,
    CFG_P_DIV     = 2'd1,
    CFG_I_DIV     = 2'd2,
    CFG_DRIFT_LIM = 2'd3
  } cfg_idx_t;

endpackage

@@ hdl/pi_clock_servo_with_step.sv @@
// Channel   Direction  Handshake            Payload
// in_       input      in_valid / in_stall  in_offset_ns (64 s)
// out_      output     out_valid/out_stall  out_step_required, out_step_seconds (35 s),
//                                           out_step_nanoseconds (31 s), out_freq_word (37 s)
// cfg_      input      cfg_we               cfg_index (2), cfg_wdata (30)
//
// One transaction at a time. A step result follows a bit-serial divide by one
// second and a check state; a slew result follows the same, then the proportional/
// integral dividers and the state that sees them finish, then the drift and the
// frequency arithmetic states.
// rst_n is synchronous: configuration returns to its defaults, drift clears.
// The result sits in an output register, so a stalled output only holds the
// final write of the next transaction, not its division.
module pi_clock_servo_with_step
  import pcs_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // input channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [63:0]  in_offset_ns,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_step_required,
  output logic signed [34:0]  out_step_seconds,
  output logic signed [30:0]  out_step_nanoseconds,
  output logic signed [36:0]  out_freq_word,
  // configuration
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [29:0]         cfg_wdata
);

  // configuration registers
  logic [29:0]        thr_r;
  logic [DIV_W-1:0]   pdiv_r;
  logic [DIV_W-1:0]   idiv_r;
  logic [19:0]        lim_r;

  state_t             state_r, state_nxt;
  logic [5:0]         cnt_r, cnt_nxt;
  logic               sign_r, sign_nxt;
  logic [63:0]        quo_r, quo_nxt;       // dividend bits out, seconds bits in
  logic [NS_W-1:0]    rem_r, rem_nxt;       // nanosecond remainder magnitude
  logic signed [DRIFT_W-1:0] drift_r, drift_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic               out_step_r, out_step_nxt;
  logic signed [34:0] out_secs_r, out_secs_nxt;
  logic signed [30:0] out_ns_r, out_ns_nxt;
  logic signed [36:0] out_fw_r, out_fw_nxt;

  // serial divide by one second
  logic [NS_W:0]      shifted;
  logic [NS_W:0]      diff;
  logic               ge;
  logic [63:0]        mag;

  logic               is_step;
  logic               out_free;

  // slew path
  logic               div_start;
  logic               pi_busy;
  logic               ii_busy;
  logic [DIV_W-1:0]   pdiv_eff;
  logic [DIV_W-1:0]   idiv_eff;
  logic [NS_W-1:0]    qp;
  logic [NS_W-1:0]    qi;
  logic signed [NS_W:0]  qp_s;
  logic signed [NS_W:0]  qi_s;
  logic signed [31:0] dsum;
  logic signed [31:0] lim_s;
  logic signed [32:0] adj;
  logic signed [39:0] adj40;
  logic signed [39:0] prod;

  assign pdiv_eff = (pdiv_r == '0) ? DIV_W'(1) : pdiv_r;
  assign idiv_eff = (idiv_r == '0) ? DIV_W'(1) : idiv_r;

  pcs_div10 u_pdiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (rem_r),
    .divisor  (pdiv_eff),
    .busy     (pi_busy),
    .quotient (qp)
  );

  pcs_div10 u_idiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (rem_r),
    .divisor  (idiv_eff),
    .busy     (ii_busy),
    .quotient (qi)
  );

  always_comb begin
    mag     = in_offset_ns[63] ? (~in_offset_ns + 64'd1) : in_offset_ns;
    shifted = {rem_r, quo_r[63]};
    ge      = shifted >= (NS_W + 1)'(NS_PER_SEC);
    diff    = shifted - (NS_W + 1)'(NS_PER_SEC);

    // seconds quotient never exceeds 34 bits; the rest stays zero
    is_step  = (quo_r[33:0] != '0) || (rem_r > thr_r);
    out_free = !out_valid_r || !out_stall;

    qp_s  = sign_r ? -$signed({1'b0, qp}) : $signed({1'b0, qp});
    qi_s  = sign_r ? -$signed({1'b0, qi}) : $signed({1'b0, qi});
    dsum  = $signed({{(32 - DRIFT_W){drift_r[DRIFT_W-1]}}, drift_r})
          + $signed({{(32 - NS_W - 1){qi_s[NS_W]}}, qi_s});
    lim_s = $signed({12'b0, lim_r});
    adj   = $signed({{(33 - NS_W - 1){qp_s[NS_W]}}, qp_s})
          + $signed({{(33 - DRIFT_W){drift_r[DRIFT_W-1]}}, drift_r});
    adj40 = $signed({{7{adj[32]}}, adj});
    prod  = adj40 * $signed(40'(FREQ_SCALE));

    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    sign_nxt      = sign_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    drift_nxt     = drift_r;
    div_start     = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    out_step_nxt  = out_step_r;
    out_secs_nxt  = out_secs_r;
    out_ns_nxt    = out_ns_r;
    out_fw_nxt    = out_fw_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          sign_nxt  = in_offset_ns[63];
          quo_nxt   = mag;
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = ST_DIVS;
        end
      end
      ST_DIVS: begin
        // one quotient bit per cycle, MSB first
        rem_nxt = ge ? diff[NS_W-1:0] : shifted[NS_W-1:0];
        quo_nxt = {quo_r[62:0], ge};
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (is_step) begin
          // drift stays; report the split offset
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_step_nxt  = 1'b1;
            out_secs_nxt  = sign_r ? -$signed({1'b0, quo_r[33:0]})
                                   : $signed({1'b0, quo_r[33:0]});
            out_ns_nxt    = sign_r ? -$signed({1'b0, rem_r}) : $signed({1'b0, rem_r});
            out_fw_nxt    = '0;
            state_nxt     = ST_IDLE;
          end
        end else begin
          div_start = 1'b1;
          state_nxt = ST_DIVI;
        end
      end
      ST_DIVI: begin
        if (!pi_busy && !ii_busy) begin
          state_nxt = ST_DRIFT;
        end
      end
      ST_DRIFT: begin
        // integrate and clamp to the symmetric limit
        if (dsum > lim_s) begin
          drift_nxt = lim_s[DRIFT_W-1:0];
        end else if (dsum < -lim_s) begin
          drift_nxt = DRIFT_W'(-lim_s);
        end else begin
          drift_nxt = dsum[DRIFT_W-1:0];
        end
        state_nxt = ST_FREQ;
      end
      ST_FREQ: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_step_nxt  = 1'b0;
          out_secs_nxt  = '0;
          out_ns_nxt    = '0;
          out_fw_nxt    = 37'(-prod);
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      drift_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      drift_r     <= drift_nxt;
      out_valid_r <= out_valid_nxt;
    end
    sign_r     <= sign_nxt;
    quo_r      <= quo_nxt;
    rem_r      <= rem_nxt;
    out_step_r <= out_step_nxt;
    out_secs_r <= out_secs_nxt;
    out_ns_r   <= out_ns_nxt;
    out_fw_r   <= out_fw_nxt;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= 30'd100000000;
      pdiv_r <= DIV_W'(2);
      idiv_r <= DIV_W'(10);
      lim_r  <= 20'd512000;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_STEP_THR:  thr_r  <= cfg_wdata;
        CFG_P_DIV:     pdiv_r <= cfg_wdata[DIV_W-1:0];
        CFG_I_DIV:     idiv_r <= cfg_wdata[DIV_W-1:0];
        CFG_DRIFT_LIM: lim_r  <= cfg_wdata[19:0];
        default: begin
        end
      endcase
    end
  end

  assign in_stall             = (state_r != ST_IDLE);
  assign out_valid            = out_valid_r;
  assign out_step_required    = out_step_r;
  assign out_step_seconds     = out_secs_r;
  assign out_step_nanoseconds = out_ns_r;
  assign out_freq_word        = out_fw_r;

endmodule

@@ hdl/pcs_div10.sv @@
// Restoring divider, one quotient bit per cycle.
module pcs_div10
  import pcs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [NS_W-1:0]   dividend,
  input  logic [DIV_W-1:0]  divisor,
  output logic              busy,
  output logic [NS_W-1:0]   quotient
);

  localparam int CNT_W = $clog2(NS_W);

  logic             busy_r, busy_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_W-1:0] rem_r, rem_nxt;
  logic [NS_W-1:0]  dvd_r, dvd_nxt;

  logic [DIV_W:0]   shifted;
  logic [DIV_W:0]   diff;
  logic             ge;

  always_comb begin
    shifted  = {rem_r, dvd_r[NS_W-1]};
    ge       = shifted >= {1'b0, divisor};
    diff     = shifted - {1'b0, divisor};
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      dvd_nxt  = dividend;
    end else if (busy_r) begin
      // shift in one dividend bit, subtract when it fits
      rem_nxt = ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
      dvd_nxt = {dvd_r[NS_W-2:0], ge};
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(NS_W - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
  end

  assign busy     = busy_r;
  assign quotient = dvd_r;

endmodule
